// ----- rtl/wtps_pkg.sv -----
package wtps_pkg;

	// Field and register widths.
	localparam int FLOW_W     = 28;
	localparam int VOL_W      = 32;
	localparam int LVL_W      = 24;
	localparam int STEP_W     = 32;
	localparam int CTRL_W     = 16;
	localparam int CLAMP_W    = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Shared multiplier: a 32-bit operand times a 28-bit operand.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 28;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Step minutes carry 24 fraction bits.
	localparam int STEP_FRAC = 24;

	localparam logic [FLOW_W-1:0]  FIVE_Q16  = 28'd327680;
	localparam logic [FLOW_W-1:0]  RAMP_Q16  = 28'd6554;
	localparam logic [CLAMP_W-1:0] FULL_CTRL = 15'd25600;

	// 25600 = 25 * 2^10: a shift, then a multiply by 2^32/25 rounded up on the
	// dividend halved, which lands within one of the quotient.
	localparam int                    CTRL_SCALE_SHIFT = 10;
	localparam int                    SCALED_W         = CLAMP_W + FLOW_W - CTRL_SCALE_SHIFT;
	localparam logic [SCALED_W:0]     SCALE_DIV        = (SCALED_W+1)'(25);
	localparam logic [MUL_B_W-1:0]    RCP_25           = 28'd171798692;
	localparam int                    RCP_SHIFT        = 31;

	localparam int                    DIV_STEP_W  = 5;
	localparam logic [DIV_STEP_W-1:0] LEVEL_STEPS = 5'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_INFLOW    = 3'd0,
		REG_MAX_OUTFLOW   = 3'd1,
		REG_TANK_CAPACITY = 3'd2,
		REG_TANK_HEIGHT   = 3'd3,
		REG_STEP_MINUTES  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ----- rtl/water_tank_plant_step_top.sv -----
// Channel   Direction  Handshake            Word
// input     in         in_valid/in_ready    control_value (signed Q8.8 percent)
// output    out        out_valid/out_ready  water_level (Q16.8 millimetres)
// config    in         cfg_wr_en            cfg_index, cfg_data
//
// When height and capacity are both nonzero, the level comes from a bit-serial
// divider that runs 24 steps; if either is zero the level is zero and no divide runs.
// The input is not ready again until the result sits in the output register, so
// a new word is not taken while the last one is still being worked.
// Reset clears the settings, empties the tank, zeroes the outflow and starts it rising.
// A stalled output holds its word; the next input is taken meanwhile.
module water_tank_plant_step_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [wtps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wtps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [wtps_pkg::CTRL_W-1:0] control_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wtps_pkg::LVL_W-1:0]        water_level
);
	import wtps_pkg::*;

	localparam int INFLOW_HI = CLAMP_W + FLOW_W - 1;
	localparam int DELTA_W   = PROD_W - STEP_FRAC;
	localparam int LVL_PROD  = VOL_W + LVL_W;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_MUL_IN  = 10'b0000000010,
		S_MUL_RCP = 10'b0000000100,
		S_FIX_IN  = 10'b0000001000,
		S_DIFF    = 10'b0000010000,
		S_MUL_DT  = 10'b0000100000,
		S_VOL     = 10'b0001000000,
		S_MUL_LVL = 10'b0010000000,
		S_DIV_LVL = 10'b0100000000,
		S_DONE    = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [FLOW_W-1:0]  max_inflow_q;
	logic [FLOW_W-1:0]  max_outflow_q;
	logic [VOL_W-1:0]   capacity_q;
	logic [LVL_W-1:0]   height_q;
	logic [STEP_W-1:0]  step_q;

	logic [VOL_W-1:0]   vol_q;
	logic [FLOW_W-1:0]  outflow_q;
	logic               rising_q;

	logic [CLAMP_W-1:0] ctrl_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [FLOW_W-1:0]  inflow_q;
	logic [FLOW_W-1:0]  mag_q;
	logic               falling_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LVL_W-1:0]   level_q;
	logic               start_q;
	logic               out_valid_q;
	logic [LVL_W-1:0]   water_level_q;

	logic [CLAMP_W-1:0] ctrl_clamp;
	logic [FLOW_W-1:0]  pin_rate;
	logic               pin_rise;
	logic [FLOW_W:0]    up_sum;
	logic [FLOW_W-1:0]  next_rate;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [FLOW_W:0]    inflow_est;
	logic [SCALED_W:0]  est_x25;
	logic [FLOW_W-1:0]  inflow_fix;
	logic [DELTA_W-1:0] delta;
	logic [DELTA_W:0]   vol_ext;
	logic [DELTA_W:0]   vol_sum;
	logic [VOL_W-1:0]   vol_next;
	logic               lvl_zero;
	logic               out_load;
	logic               in_fire;

	div_cmd_t           div_cmd;
	div_sts_t           div_sts;
	logic [VOL_W-1:0]   div_rem;
	logic [FLOW_W-1:0]  div_bits;
	logic [VOL_W-1:0]   div_divisor;
	logic [FLOW_W-1:0]  div_quo;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign lvl_zero = (capacity_q == '0) || (height_q == '0);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		if (control_value[CTRL_W-1]) begin
			ctrl_clamp = '0;
		end else if (control_value[CLAMP_W-1:0] > FULL_CTRL) begin
			ctrl_clamp = FULL_CTRL;
		end else begin
			ctrl_clamp = control_value[CLAMP_W-1:0];
		end
	end

	// Triangle outflow: pin at a turning point, then take one ramp step.
	always_comb begin
		pin_rate = outflow_q;
		pin_rise = rising_q;
		if (outflow_q >= max_outflow_q) begin
			pin_rise = 1'b0;
			pin_rate = max_outflow_q;
		end else if (outflow_q <= FIVE_Q16) begin
			pin_rise = 1'b1;
			pin_rate = FIVE_Q16;
		end
		up_sum = {1'b0, pin_rate} + {1'b0, RAMP_Q16};
		if (pin_rise) begin
			next_rate = up_sum[FLOW_W] ? '1 : up_sum[FLOW_W-1:0];
		end else begin
			next_rate = (pin_rate >= RAMP_Q16) ? pin_rate - RAMP_Q16 : '0;
		end
	end

	always_comb begin
		case (state_q)
			S_MUL_RCP: begin
				mul_a = prod_q[INFLOW_HI:CTRL_SCALE_SHIFT+1];
				mul_b = RCP_25;
			end
			S_MUL_DT: begin
				mul_a = step_q;
				mul_b = mag_q;
			end
			S_MUL_LVL: begin
				mul_a = vol_q;
				mul_b = MUL_B_W'(height_q);
			end
			default: begin
				mul_a = MUL_A_W'(max_inflow_q);
				mul_b = MUL_B_W'(ctrl_q);
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// The reciprocal estimate of the scaled product over 25 is within one of the
	// true quotient; one compare on each side settles it.
	always_comb begin
		inflow_est = prod_q[PROD_W-1:RCP_SHIFT];
		est_x25    = (SCALED_W+1)'({inflow_est, 4'b0}) + (SCALED_W+1)'({inflow_est, 3'b0})
		           + (SCALED_W+1)'(inflow_est);
		if (est_x25 > {1'b0, scaled_q}) begin
			inflow_fix = FLOW_W'(inflow_est - 1'b1);
		end else if (({1'b0, scaled_q} - est_x25) >= SCALE_DIV) begin
			inflow_fix = FLOW_W'(inflow_est + 1'b1);
		end else begin
			inflow_fix = FLOW_W'(inflow_est);
		end
	end

	assign delta   = prod_q[PROD_W-1:STEP_FRAC];
	assign vol_ext = (DELTA_W+1)'(vol_q);

	always_comb begin
		if (falling_q) begin
			vol_sum = ({1'b0, delta} > vol_ext) ? '0 : vol_ext - {1'b0, delta};
		end else begin
			vol_sum = vol_ext + {1'b0, delta};
		end
		vol_next = (vol_sum > (DELTA_W+1)'(capacity_q)) ? capacity_q : vol_sum[VOL_W-1:0];
	end

	// Level divides volume times height by capacity. The volume never exceeds
	// the capacity, so the quotient fits the step count.
	always_comb begin
		div_cmd.start = start_q;
		div_cmd.steps = LEVEL_STEPS;
		div_rem       = prod_q[LVL_PROD-1:LVL_W];
		div_bits      = {prod_q[LVL_W-1:0], (FLOW_W-LVL_W)'(0)};
		div_divisor   = capacity_q;
	end

	wtps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.rem_init  (div_rem),
		.bits_init (div_bits),
		.divisor   (div_divisor),
		.sts       (div_sts),
		.quotient  (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_inflow_q  <= '0;
			max_outflow_q <= '0;
			capacity_q    <= '0;
			height_q      <= '0;
			step_q        <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_INFLOW:    max_inflow_q  <= cfg_data[FLOW_W-1:0];
				REG_MAX_OUTFLOW:   max_outflow_q <= cfg_data[FLOW_W-1:0];
				REG_TANK_CAPACITY: capacity_q    <= cfg_data[VOL_W-1:0];
				REG_TANK_HEIGHT:   height_q      <= cfg_data[LVL_W-1:0];
				REG_STEP_MINUTES:  step_q        <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vol_q       <= '0;
			outflow_q   <= '0;
			rising_q    <= 1'b1;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_load) begin
				out_valid_q   <= 1'b1;
				water_level_q <= level_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						ctrl_q    <= ctrl_clamp;
						outflow_q <= next_rate;
						rising_q  <= pin_rise;
						state_q   <= S_MUL_IN;
					end
				end
				S_MUL_IN: begin
					prod_q  <= mul_p;
					state_q <= S_MUL_RCP;
				end
				S_MUL_RCP: begin
					scaled_q <= prod_q[INFLOW_HI:CTRL_SCALE_SHIFT];
					prod_q   <= mul_p;
					state_q  <= S_FIX_IN;
				end
				S_FIX_IN: begin
					inflow_q <= inflow_fix;
					state_q  <= S_DIFF;
				end
				S_DIFF: begin
					falling_q <= inflow_q < outflow_q;
					mag_q     <= (inflow_q < outflow_q) ? outflow_q - inflow_q
					                                    : inflow_q - outflow_q;
					state_q   <= S_MUL_DT;
				end
				S_MUL_DT: begin
					prod_q  <= mul_p;
					state_q <= S_VOL;
				end
				S_VOL: begin
					vol_q   <= vol_next;
					state_q <= S_MUL_LVL;
				end
				S_MUL_LVL: begin
					prod_q <= mul_p;
					if (lvl_zero) begin
						level_q <= '0;
						state_q <= S_DONE;
					end else begin
						start_q <= 1'b1;
						state_q <= S_DIV_LVL;
					end
				end
				S_DIV_LVL: begin
					if (div_sts.done) begin
						level_q <= (div_quo[LVL_W-1:0] > height_q) ? height_q
						                                            : div_quo[LVL_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign water_level = water_level_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input ready right after a word was accepted");
	a_volume_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VOL) |=> (vol_q <= capacity_q))
		else $error("stored volume above capacity");
	a_level_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (water_level <= height_q))
		else $error("level above tank height");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (state_q == S_DIV_LVL))
		else $error("divider started outside a divide state");
`endif

endmodule

// ----- rtl/wtps_div.sv -----
module wtps_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wtps_pkg::div_cmd_t            cmd,
	input  logic [wtps_pkg::VOL_W-1:0]    rem_init,
	input  logic [wtps_pkg::FLOW_W-1:0]   bits_init,
	input  logic [wtps_pkg::VOL_W-1:0]    divisor,
	output wtps_pkg::div_sts_t            sts,
	output logic [wtps_pkg::FLOW_W-1:0]   quotient
);
	import wtps_pkg::*;

	logic [VOL_W-1:0]      rem_q;
	logic [VOL_W-1:0]      div_q;
	logic [FLOW_W-1:0]     bits_q;
	logic [FLOW_W-1:0]     quo_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [VOL_W:0]        trial;
	logic                  fits;

	// The partial remainder stays below the divisor, so one bit brought down
	// never needs more than one subtraction.
	assign trial = {rem_q, bits_q[FLOW_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				rem_q  <= rem_init;
				bits_q <= bits_init;
				div_q  <= divisor;
				cnt_q  <= cmd.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= fits ? VOL_W'(trial - {1'b0, div_q}) : trial[VOL_W-1:0];
				bits_q <= {bits_q[FLOW_W-2:0], 1'b0};
				quo_q  <= {quo_q[FLOW_W-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("divider started while busy");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("divider busy with no steps left");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("divider done without a finished run");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import wtps_pkg::*;

	localparam logic [27:0]          FIVE_LPM     = 28'd327680;
	localparam logic [27:0]          RAMP_STEP    = 28'd6554;
	localparam int                   FULL_SCALE   = 25600;
	localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 3'd5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CTRL_W-1:0] control_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [LVL_W-1:0] water_level;

	// Plant settings and state as the predictor sees them.
	logic [27:0] set_max_inflow = '0;
	logic [27:0] set_max_outflow = '0;
	logic [31:0] set_capacity = '0;
	logic [23:0] set_height = '0;
	logic [31:0] set_step = '0;
	logic [31:0] tank_volume = '0;
	logic [27:0] tank_outflow = '0;
	logic        tank_rising = 1'b1;

	logic signed [CTRL_W-1:0] control_queue[$];
	logic [LVL_W-1:0]         level_queue[$];
	logic in_taken = 1'b0;
	int   gap_left = 0;
	int   burst_left = 1;
	int   ready_left = 0;
	int   fail_count = 0;

	water_tank_plant_step_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.control_value(control_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.water_level(water_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One plant step: move the outflow ramp, integrate the volume, scale to a level.
	function automatic logic [LVL_W-1:0] plant_step(input logic signed [CTRL_W-1:0] cv);
		logic [14:0]        pct;
		logic [28:0]        up;
		logic [63:0]        inflow;
		logic [63:0]        mag;
		logic [63:0]        lvl;
		logic signed [63:0] vol;
		logic               falling;
		if (cv < 0) begin
			pct = '0;
		end else if (cv > FULL_SCALE) begin
			pct = 15'(FULL_SCALE);
		end else begin
			pct = cv[14:0];
		end

		if (tank_outflow >= set_max_outflow) begin
			tank_rising = 1'b0;
			tank_outflow = set_max_outflow;
		end else if (tank_outflow <= FIVE_LPM) begin
			tank_rising = 1'b1;
			tank_outflow = FIVE_LPM;
		end
		if (tank_rising) begin
			up = {1'b0, tank_outflow} + {1'b0, RAMP_STEP};
			tank_outflow = up[28] ? '1 : up[27:0];
		end else begin
			tank_outflow = (tank_outflow >= RAMP_STEP) ? tank_outflow - RAMP_STEP : '0;
		end

		inflow = (64'(pct) * 64'(set_max_inflow)) / 64'(FULL_SCALE);
		falling = inflow < 64'(tank_outflow);
		mag = falling ? 64'(tank_outflow) - inflow : inflow - 64'(tank_outflow);
		mag = (mag * 64'(set_step)) >> STEP_FRAC;

		vol = signed'(64'(tank_volume));
		vol = falling ? vol - signed'(mag) : vol + signed'(mag);
		if (vol < 0)
			vol = 0;
		if (vol > signed'(64'(set_capacity)))
			vol = signed'(64'(set_capacity));
		tank_volume = vol[31:0];

		if (set_height != 0 && set_capacity != 0) begin
			lvl = (64'(tank_volume) * 64'(set_height)) / 64'(set_capacity);
			if (lvl > 64'(set_height))
				lvl = 64'(set_height);
			return lvl[LVL_W-1:0];
		end
		return '0;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_MAX_INFLOW:    set_max_inflow = data[27:0];
			REG_MAX_OUTFLOW:   set_max_outflow = data[27:0];
			REG_TANK_CAPACITY: set_capacity = data;
			REG_TANK_HEIGHT:   set_height = data[23:0];
			REG_STEP_MINUTES:  set_step = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Returns once every word has been taken and every level has come back.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (control_queue.size() != 0 || in_valid || level_queue.size() != 0);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(0, 2))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic rand_config();
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_MAX_INFLOW, extreme_word());
			write_reg(REG_MAX_OUTFLOW, extreme_word());
			write_reg(REG_TANK_CAPACITY, extreme_word());
			write_reg(REG_TANK_HEIGHT, extreme_word());
			write_reg(REG_STEP_MINUTES, extreme_word());
		end else begin
			write_reg(REG_MAX_INFLOW, ($urandom_range(1, 200) << 16) | $urandom_range(0, 65535));
			write_reg(REG_MAX_OUTFLOW, ($urandom_range(0, 80) << 16) | $urandom_range(0, 65535));
			write_reg(REG_TANK_CAPACITY,
				($urandom_range(1, 400) << 16) | $urandom_range(0, 65535));
			write_reg(REG_TANK_HEIGHT, ($urandom_range(1, 4000) << 8) | $urandom_range(0, 255));
			write_reg(REG_STEP_MINUTES, $urandom_range(1, 32'h0100_0000));
		end
	endtask

	function automatic logic signed [CTRL_W-1:0] rand_control();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return CTRL_W'($urandom_range(0, FULL_SCALE));
			6, 7:             return CTRL_W'($urandom);
			8:                return CTRL_W'($urandom_range(FULL_SCALE - 5, FULL_SCALE + 5));
			default:          return CTRL_W'($urandom_range(0, 6)) - 16'sd3;
		endcase
	endfunction

	// Sender: bursts of words separated by random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (control_queue.size() != 0) begin
					in_valid <= 1'b1;
					control_value <= control_queue.pop_front();
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(1, 12);
						case ($urandom_range(0, 3))
							0: gap_left <= 0;
							1: gap_left <= $urandom_range(1, 4);
							2: gap_left <= $urandom_range(5, 40);
							default: gap_left <= $urandom_range(40, 120);
						endcase
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: alternating ready and stall stretches of random length.
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_left == 0) begin
				out_ready <= !out_ready;
				ready_left <= out_ready ? $urandom_range(1, 70) : $urandom_range(1, 90);
			end else begin
				ready_left <= ready_left - 1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		logic [LVL_W-1:0] want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				level_queue.push_back(plant_step(control_value));
			if (out_valid && out_ready) begin
				if (level_queue.size() == 0) begin
					$error("water_level: expected no word, got %0d", water_level);
					fail_count++;
				end else begin
					want = level_queue.pop_front();
					if (water_level !== want) begin
						$error("water_level: expected %0d, got %0d", want, water_level);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers still at reset: zero height and capacity, outflow pinned at zero.
		control_queue.push_back(-16'sd1);
		control_queue.push_back(16'sd25600);
		wait_idle();

		// A realistic tank; upper bits of the data must be dropped.
		write_reg(REG_MAX_INFLOW, 32'hF064_0000);
		write_reg(REG_MAX_OUTFLOW, 32'd20 << 16);
		write_reg(REG_TANK_CAPACITY, 32'd50 << 16);
		write_reg(REG_TANK_HEIGHT, 32'hAB01_F400);
		write_reg(REG_STEP_MINUTES, 32'd279620);
		control_queue.push_back(-16'sd32768);
		control_queue.push_back(-16'sd1);
		control_queue.push_back(16'sd0);
		control_queue.push_back(16'sd1);
		control_queue.push_back(16'sd12800);
		control_queue.push_back(16'sd25599);
		control_queue.push_back(16'sd25600);
		control_queue.push_back(16'sd25601);
		control_queue.push_back(16'sd32767);
		control_queue.push_back(16'sh5555);
		control_queue.push_back(16'shAAAA);
		wait_idle();

		// Zero height, then zero capacity: the level reads zero.
		write_reg(REG_TANK_HEIGHT, 32'd0);
		control_queue.push_back(16'sd25600);
		control_queue.push_back(16'sd0);
		wait_idle();
		write_reg(REG_TANK_HEIGHT, 32'd300 << 8);
		write_reg(REG_TANK_CAPACITY, 32'd0);
		control_queue.push_back(16'sd25600);
		control_queue.push_back(16'sd6400);
		wait_idle();

		// Upper turning point below one ramp step, so the falling ramp bottoms out
		// at zero. Writes to unmapped indexes must change nothing.
		write_reg(REG_TANK_CAPACITY, 32'd50 << 16);
		write_reg(REG_MAX_OUTFLOW, 32'd100);
		for (int i = IDX_UNMAPPED; i < 8; i++)
			write_reg(CFG_IDX_W'(i), 32'hFFFF_FFFF);
		repeat (3) control_queue.push_back(16'sd3000);
		wait_idle();

		// Fill a large tank fast, then shrink it below the stored volume.
		write_reg(REG_MAX_INFLOW, 32'd4000 << 16);
		write_reg(REG_STEP_MINUTES, 32'h0100_0000);
		write_reg(REG_TANK_CAPACITY, 32'd20000 << 16);
		write_reg(REG_TANK_HEIGHT, 32'd1000 << 8);
		repeat (3) control_queue.push_back(16'sd25600);
		wait_idle();
		write_reg(REG_TANK_CAPACITY, 32'd5000 << 16);
		control_queue.push_back(16'sd12800);
		control_queue.push_back(16'sd0);
		wait_idle();

		for (int phase = 0; phase < 10; phase++) begin
			rand_config();
			repeat (75) control_queue.push_back(rand_control());
			wait_idle();
		end

		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/wtps_pkg.sv
rtl/wtps_div.sv
rtl/water_tank_plant_step_top.sv
dv/tb.sv
